@@ sv/pcm_clock_presence_monitor_assert.svh @@
// assertion macros for the clock presence monitor
// clock and reset are the names of the enclosing module's clock and reset
`ifndef PCM_CLOCK_PRESENCE_MONITOR_ASSERT_SVH
`define PCM_CLOCK_PRESENCE_MONITOR_ASSERT_SVH

// same-cycle implication
`define PCM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcm monitor check failed");

// next-cycle implication
`define PCM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcm monitor check failed");

`endif

@@ sv/pcm_pkg.sv @@
package pcm_pkg;

   localparam int WINDOW_SAMPLES    = 400;
   localparam int BURST_HALF_CYCLES = 16;
   localparam int REQ_FIFO_DEPTH    = 2;

   localparam int SMP_W   = $clog2(WINDOW_SAMPLES + 1);
   localparam int BURST_W = $clog2(BURST_HALF_CYCLES + 1);
   localparam int FPTR_W  = (REQ_FIFO_DEPTH > 1) ? $clog2(REQ_FIFO_DEPTH) : 1;
   localparam int FCNT_W  = $clog2(REQ_FIFO_DEPTH + 1);

   localparam int EDGE_W  = 9;
   localparam int THR_W   = 9;
   localparam int GAP_W   = 16;
   localparam int STATE_W = 3;
   localparam int MODE_W  = 2;
   localparam int EVENT_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_GAP       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_ACTIVE_LOW = 2'd3;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 9'd10;
   localparam logic [GAP_W-1:0] POLL_GAP_RESET  = 16'd5000;

   // monitor states
   localparam logic [STATE_W-1:0] ST_DISABLED   = 3'd0;
   localparam logic [STATE_W-1:0] ST_ENABLED    = 3'd1;
   localparam logic [STATE_W-1:0] ST_LOST       = 3'd2;
   localparam logic [STATE_W-1:0] ST_SYNC       = 3'd3;
   localparam logic [STATE_W-1:0] ST_GENERATING = 3'd4;

   // interface modes
   localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MASTER   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SLAVE    = 2'd2;

   // events
   localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
   localparam logic [EVENT_W-1:0] EV_SYNC = 2'd1;
   localparam logic [EVENT_W-1:0] EV_LOST = 2'd2;

   typedef struct packed {
      logic              enable;
      logic [THR_W-1:0]  edge_threshold;
      logic [GAP_W-1:0]  poll_gap;
      logic              ext_active_low;
   } pcm_cfg_type;

   typedef struct packed {
      logic dcl_level;
      logic start_request;
   } pcm_req_type;

   typedef struct packed {
      logic [STATE_W-1:0] clock_state;
      logic [MODE_W-1:0]  interface_mode;
      logic               dcl_drive;
      logic               fsc_drive;
      logic               ext_pin_level;
      logic [EVENT_W-1:0] event_code;
   } pcm_rsp_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } pcm_fifo_status_type;

endpackage

@@ sv/pcm_if.sv @@
interface pcm_req_if;
   logic valid;
   logic ready;
   logic dcl_level;
   logic start_request;

   modport source (output valid, output dcl_level, output start_request, input ready);
   modport sink (input valid, input dcl_level, input start_request, output ready);
endinterface

interface pcm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pcm_pkg::STATE_W-1:0]      clock_state;
   logic [pcm_pkg::MODE_W-1:0]       interface_mode;
   logic                             dcl_drive;
   logic                             fsc_drive;
   logic                             ext_pin_level;
   logic [pcm_pkg::EVENT_W-1:0]      event_code;

   modport source (output valid, output clock_state, output interface_mode,
                   output dcl_drive, output fsc_drive, output ext_pin_level,
                   output event_code, input ready);
   modport sink (input valid, input clock_state, input interface_mode,
                 input dcl_drive, input fsc_drive, input ext_pin_level,
                 input event_code, output ready);
endinterface

@@ sv/pcm_req_fifo.sv @@
module pcm_req_fifo (
   input  logic                         clock,
   input  logic                         reset,
   pcm_req_if.sink                      req_ch,
   input  logic                         pop,
   output pcm_pkg::pcm_req_type         head,
   output pcm_pkg::pcm_fifo_status_type status
);

   localparam int DEPTH = pcm_pkg::REQ_FIFO_DEPTH;
   localparam logic [pcm_pkg::FPTR_W-1:0] LAST_PTR = pcm_pkg::FPTR_W'(DEPTH - 1);
   localparam logic [pcm_pkg::FCNT_W-1:0] FULL_CNT = pcm_pkg::FCNT_W'(DEPTH);

   pcm_pkg::pcm_req_type            mem_ff [DEPTH];
   logic [pcm_pkg::FPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pcm_pkg::FPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pcm_pkg::FCNT_W-1:0]      cnt_ff, cnt_in;
   logic                            push;
   logic                            do_pop;

   assign status.full      = (cnt_ff == FULL_CNT);
   assign status.not_empty = (cnt_ff != '0);
   assign req_ch.ready     = !status.full;
   assign push             = req_ch.valid && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign head             = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{dcl_level: req_ch.dcl_level,
                                start_request: req_ch.start_request};
      end
   end

endmodule

@@ sv/pcm_mon_core.sv @@
module pcm_mon_core (
   input  logic                         clock,
   input  logic                         reset,
   input  pcm_pkg::pcm_cfg_type         cfg,
   input  pcm_pkg::pcm_fifo_status_type fifo_st,
   input  pcm_pkg::pcm_req_type         head,
   output logic                         pop,
   pcm_rsp_if.source                    rsp_ch
);

   localparam logic [pcm_pkg::SMP_W-1:0]   WIN_END =
      pcm_pkg::SMP_W'(pcm_pkg::WINDOW_SAMPLES);
   localparam logic [pcm_pkg::BURST_W-1:0] BURST_END =
      pcm_pkg::BURST_W'(pcm_pkg::BURST_HALF_CYCLES);

   logic [pcm_pkg::STATE_W-1:0] state_ff, state_in;
   logic [pcm_pkg::SMP_W-1:0]   smp_cnt_ff, smp_cnt_in;
   logic [pcm_pkg::EDGE_W-1:0]  edge_cnt_ff, edge_cnt_in;
   logic                        prev_ff, prev_in;
   logic                        ref_pend_ff, ref_pend_in;
   logic [pcm_pkg::GAP_W-1:0]   gap_cnt_ff, gap_cnt_in;
   logic                        in_gap_ff, in_gap_in;
   logic [pcm_pkg::BURST_W-1:0] burst_cnt_ff, burst_cnt_in;
   logic                        burst_lvl_ff, burst_lvl_in;
   logic                        saved_ext_ff, saved_ext_in;
   logic                        ext_log_ff, ext_log_in;

   pcm_pkg::pcm_rsp_type        out_ff, out_in;
   logic                        out_valid_ff;

   logic                        advance;
   logic                        do_poll;
   logic                        do_burst;
   logic                        gap_go;
   logic                        present;
   logic                        dcl;
   logic                        fsc;
   logic [pcm_pkg::EVENT_W-1:0] ev;
   logic [pcm_pkg::MODE_W-1:0]  mode;

   assign advance = fifo_st.not_empty && (!out_valid_ff || rsp_ch.ready);
   assign pop     = advance;

   always_comb begin
      state_in     = state_ff;
      smp_cnt_in   = smp_cnt_ff;
      edge_cnt_in  = edge_cnt_ff;
      prev_in      = prev_ff;
      ref_pend_in  = ref_pend_ff;
      gap_cnt_in   = gap_cnt_ff;
      in_gap_in    = in_gap_ff;
      burst_cnt_in = burst_cnt_ff;
      burst_lvl_in = burst_lvl_ff;
      saved_ext_in = saved_ext_ff;
      ext_log_in   = ext_log_ff;
      do_poll      = 1'b0;
      do_burst     = 1'b0;
      gap_go       = 1'b0;
      present      = 1'b0;
      dcl          = 1'b0;
      fsc          = 1'b0;
      ev           = pcm_pkg::EV_NONE;

      if (!cfg.enable) begin
         state_in     = pcm_pkg::ST_DISABLED;
         ext_log_in   = 1'b0;
         burst_cnt_in = '0;
         burst_lvl_in = 1'b0;
         ref_pend_in  = 1'b1;
         in_gap_in    = 1'b0;
         gap_cnt_in   = '0;
         smp_cnt_in   = '0;
         edge_cnt_in  = '0;
      end else if (state_ff == pcm_pkg::ST_DISABLED) begin
         state_in    = pcm_pkg::ST_ENABLED;
         ext_log_in  = 1'b1;
         ref_pend_in = 1'b1;
         in_gap_in   = 1'b0;
         gap_cnt_in  = '0;
         smp_cnt_in  = '0;
         edge_cnt_in = '0;
         do_poll     = 1'b1;
      end else if (state_ff == pcm_pkg::ST_GENERATING) begin
         do_burst = 1'b1;
      end else if (head.start_request && (state_ff == pcm_pkg::ST_ENABLED ||
                                          state_ff == pcm_pkg::ST_LOST)) begin
         state_in     = pcm_pkg::ST_GENERATING;
         saved_ext_in = ext_log_ff;
         ext_log_in   = 1'b0;
         burst_cnt_in = '0;
         burst_lvl_in = 1'b0;
         do_burst     = 1'b1;
      end else begin
         do_poll = 1'b1;
      end

      if (do_burst) begin
         burst_lvl_in = ~burst_lvl_in;
         dcl          = burst_lvl_in;
         fsc          = (burst_cnt_in == '0);
         burst_cnt_in = burst_cnt_in + 1'b1;
         if (burst_cnt_in >= BURST_END) begin
            state_in     = pcm_pkg::ST_LOST;
            burst_cnt_in = '0;
            burst_lvl_in = 1'b0;
            if (saved_ext_in) begin
               ext_log_in = 1'b1;
            end
            gap_go = 1'b1;
         end
      end

      if (do_poll) begin
         if (in_gap_in) begin
            gap_cnt_in = gap_cnt_in + 1'b1;
            if (gap_cnt_in >= cfg.poll_gap) begin
               ref_pend_in = 1'b1;
               in_gap_in   = 1'b0;
               gap_cnt_in  = '0;
               smp_cnt_in  = '0;
               edge_cnt_in = '0;
            end
         end else if (ref_pend_in) begin
            prev_in     = head.dcl_level;
            ref_pend_in = 1'b0;
            smp_cnt_in  = '0;
            edge_cnt_in = '0;
         end else begin
            if (head.dcl_level != prev_in) begin
               if (edge_cnt_in != pcm_pkg::EDGE_MAX) begin
                  edge_cnt_in = edge_cnt_in + 1'b1;
               end
               prev_in = head.dcl_level;
            end
            smp_cnt_in = smp_cnt_in + 1'b1;
            if (smp_cnt_in >= WIN_END) begin
               present = (edge_cnt_in > cfg.edge_threshold);
               case (state_in)
                  pcm_pkg::ST_ENABLED: begin
                     state_in = present ? pcm_pkg::ST_SYNC : pcm_pkg::ST_LOST;
                     ev       = present ? pcm_pkg::EV_SYNC : pcm_pkg::EV_LOST;
                  end
                  pcm_pkg::ST_LOST: begin
                     if (present) begin
                        state_in = pcm_pkg::ST_SYNC;
                        ev       = pcm_pkg::EV_SYNC;
                     end
                  end
                  pcm_pkg::ST_SYNC: begin
                     if (!present) begin
                        state_in = pcm_pkg::ST_LOST;
                        ev       = pcm_pkg::EV_LOST;
                     end
                  end
                  default: begin
                  end
               endcase
               gap_go = 1'b1;
            end
         end
      end

      // end of a window or a burst: wait out the poll gap
      if (gap_go) begin
         smp_cnt_in  = '0;
         edge_cnt_in = '0;
         gap_cnt_in  = '0;
         if (cfg.poll_gap == '0) begin
            ref_pend_in = 1'b1;
            in_gap_in   = 1'b0;
         end else begin
            ref_pend_in = 1'b0;
            in_gap_in   = 1'b1;
         end
      end
   end

   always_comb begin
      case (state_in)
         pcm_pkg::ST_DISABLED:   mode = pcm_pkg::MODE_DISABLED;
         pcm_pkg::ST_GENERATING: mode = pcm_pkg::MODE_MASTER;
         default:                mode = pcm_pkg::MODE_SLAVE;
      endcase
      out_in.clock_state    = state_in;
      out_in.interface_mode = mode;
      out_in.dcl_drive      = (mode == pcm_pkg::MODE_MASTER) && dcl;
      out_in.fsc_drive      = (mode == pcm_pkg::MODE_MASTER) && fsc;
      out_in.ext_pin_level  = ext_log_in ^ cfg.ext_active_low;
      out_in.event_code     = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcm_pkg::ST_DISABLED;
         smp_cnt_ff   <= '0;
         edge_cnt_ff  <= '0;
         prev_ff      <= 1'b0;
         ref_pend_ff  <= 1'b1;
         gap_cnt_ff   <= '0;
         in_gap_ff    <= 1'b0;
         burst_cnt_ff <= '0;
         burst_lvl_ff <= 1'b0;
         saved_ext_ff <= 1'b0;
         ext_log_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            smp_cnt_ff   <= smp_cnt_in;
            edge_cnt_ff  <= edge_cnt_in;
            prev_ff      <= prev_in;
            ref_pend_ff  <= ref_pend_in;
            gap_cnt_ff   <= gap_cnt_in;
            in_gap_ff    <= in_gap_in;
            burst_cnt_ff <= burst_cnt_in;
            burst_lvl_ff <= burst_lvl_in;
            saved_ext_ff <= saved_ext_in;
            ext_log_ff   <= ext_log_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.clock_state    = out_ff.clock_state;
   assign rsp_ch.interface_mode = out_ff.interface_mode;
   assign rsp_ch.dcl_drive      = out_ff.dcl_drive;
   assign rsp_ch.fsc_drive      = out_ff.fsc_drive;
   assign rsp_ch.ext_pin_level  = out_ff.ext_pin_level;
   assign rsp_ch.event_code     = out_ff.event_code;

endmodule

@@ sv/pcm_clock_presence_monitor.sv @@
// PCM bit-clock presence monitor: one sample tick in, one status result out. Ticks
// enter a two-entry queue that a state update drains into an output register, so the
// block takes one tick per clock cycle for as long as results are taken, and a tick's
// result passes the queue and the output register before it reaches rsp. A stalled
// result side holds up to three ticks before req ready drops. Detection runs in
// windows of one reference sample plus 400 compared samples, separated by poll_gap
// idle ticks; a start request in the enabled or lost state plays a 16 half-cycle master
// burst instead. Registers (enable, edge_threshold, poll_gap, ext_active_low) are for
// the user to write via csr port only while no tick is in flight; the block won't check.
`include "pcm_clock_presence_monitor_assert.svh"

module pcm_clock_presence_monitor (
   input  logic                              clock,
   input  logic                              reset,
   pcm_req_if.sink                           req_ch,
   pcm_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [pcm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pcm_pkg::pcm_cfg_type         cfg_ff, cfg_in;
   pcm_pkg::pcm_fifo_status_type fifo_st;
   pcm_pkg::pcm_req_type         head;
   logic                         pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pcm_pkg::CSR_ENABLE:         cfg_in.enable = csr_wdata[0];
            pcm_pkg::CSR_EDGE_THRESHOLD: cfg_in.edge_threshold =
                                            csr_wdata[pcm_pkg::THR_W-1:0];
            pcm_pkg::CSR_POLL_GAP:       cfg_in.poll_gap = csr_wdata[pcm_pkg::GAP_W-1:0];
            pcm_pkg::CSR_EXT_ACTIVE_LOW: cfg_in.ext_active_low = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable         <= 1'b0;
         cfg_ff.edge_threshold <= pcm_pkg::THRESHOLD_RESET;
         cfg_ff.poll_gap       <= pcm_pkg::POLL_GAP_RESET;
         cfg_ff.ext_active_low <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pcm_req_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .pop    (pop),
      .head   (head),
      .status (fifo_st)
   );

   pcm_mon_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .fifo_st (fifo_st),
      .head    (head),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

   // a transfer in always leaves the queue holding something next cycle
   `PCM_ASSERT_NEXT(a_push_lands, req_ch.valid && req_ch.ready, fifo_st.not_empty)
   `PCM_ASSERT_SAME(a_drive_master_only, rsp_ch.valid && (rsp_ch.interface_mode != pcm_pkg::MODE_MASTER), !rsp_ch.dcl_drive && !rsp_ch.fsc_drive)
   `PCM_ASSERT_SAME(a_sync_event_state, rsp_ch.valid && (rsp_ch.event_code == pcm_pkg::EV_SYNC), rsp_ch.clock_state == pcm_pkg::ST_SYNC)
   `PCM_ASSERT_SAME(a_lost_event_state, rsp_ch.valid && (rsp_ch.event_code == pcm_pkg::EV_LOST), rsp_ch.clock_state == pcm_pkg::ST_LOST)

endmodule

@@ tb/tb_pcm_clock_presence_monitor.sv @@
`timescale 1ns / 1ps

module tb_pcm_clock_presence_monitor;

   localparam int HOLD_CYCLES   = 80;
   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                   kind;
      logic [pcm_pkg::CSR_IDX_W-1:0]  index;
      logic [pcm_pkg::CSR_DATA_W-1:0] data;
      logic                           level;
      logic                           start;
      bit                             typed;
      pcm_pkg::pcm_rsp_type           want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_we;
   logic [pcm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pcm_pkg::CSR_DATA_W-1:0] csr_wdata;

   pcm_req_if req_bus ();
   pcm_rsp_if rsp_bus ();

   pcm_clock_presence_monitor uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // configuration copy
   logic                       cfg_enable;
   logic [pcm_pkg::THR_W-1:0]  cfg_threshold;
   logic [pcm_pkg::GAP_W-1:0]  cfg_gap;
   logic                       cfg_active_low;

   // monitor state copy
   logic [pcm_pkg::STATE_W-1:0] mon_state;
   logic [pcm_pkg::SMP_W-1:0]   smp_count;
   logic [pcm_pkg::EDGE_W-1:0]  edge_count;
   logic                        prev_level;
   logic                        ref_due;
   logic [pcm_pkg::GAP_W-1:0]   gap_count;
   logic                        in_gap;
   logic [pcm_pkg::BURST_W-1:0] burst_count;
   logic                        burst_level;
   logic                        saved_ext;
   logic                        ext_logical;

   pcm_pkg::pcm_rsp_type pending_status[$];
   dir_row_type          dir_rows[$];

   int error_count  = 0;
   int ticks_sent   = 0;
   int results_seen = 0;
   int sync_events  = 0;
   int lost_events  = 0;
   int bursts_seen  = 0;
   int quiet_cycles = 0;
   int hold_cycles  = 0;
   int stall_pct    = 0;
   bit hold_req     = 1'b0;
   bit hold_done    = 1'b0;

   function automatic void window_restart();
      ref_due   = 1'b1;
      in_gap    = 1'b0;
      gap_count = '0;
      smp_count = '0;
      edge_count = '0;
   endfunction

   function automatic void gap_enter();
      smp_count  = '0;
      edge_count = '0;
      if (cfg_gap == '0) begin
         window_restart();
      end else begin
         in_gap    = 1'b1;
         gap_count = '0;
         ref_due   = 1'b0;
      end
   endfunction

   function automatic void model_reset();
      cfg_enable     = 1'b0;
      cfg_threshold  = pcm_pkg::THRESHOLD_RESET;
      cfg_gap        = pcm_pkg::POLL_GAP_RESET;
      cfg_active_low = 1'b0;
      mon_state      = pcm_pkg::ST_DISABLED;
      prev_level     = 1'b0;
      burst_count    = '0;
      burst_level    = 1'b0;
      saved_ext      = 1'b0;
      ext_logical    = 1'b0;
      window_restart();
   endfunction

   // one polling tick, returns the event it raises
   function automatic logic [pcm_pkg::EVENT_W-1:0] detect_tick(input logic level);
      logic                        present;
      logic [pcm_pkg::EVENT_W-1:0] ev;
      ev = pcm_pkg::EV_NONE;
      if (in_gap) begin
         gap_count = gap_count + 1'b1;
         if (gap_count >= cfg_gap) window_restart();
         return ev;
      end
      if (ref_due) begin
         prev_level = level;
         ref_due    = 1'b0;
         smp_count  = '0;
         edge_count = '0;
         return ev;
      end
      if (level != prev_level) begin
         if (edge_count != pcm_pkg::EDGE_MAX) edge_count = edge_count + 1'b1;
         prev_level = level;
      end
      smp_count = smp_count + 1'b1;
      if (smp_count < pcm_pkg::WINDOW_SAMPLES) return ev;
      present = edge_count > cfg_threshold;
      case (mon_state)
         pcm_pkg::ST_ENABLED: begin
            mon_state = present ? pcm_pkg::ST_SYNC : pcm_pkg::ST_LOST;
            ev = present ? pcm_pkg::EV_SYNC : pcm_pkg::EV_LOST;
         end
         pcm_pkg::ST_LOST: begin
            if (present) begin
               mon_state = pcm_pkg::ST_SYNC;
               ev = pcm_pkg::EV_SYNC;
            end
         end
         pcm_pkg::ST_SYNC: begin
            if (!present) begin
               mon_state = pcm_pkg::ST_LOST;
               ev = pcm_pkg::EV_LOST;
            end
         end
         default: ;
      endcase
      gap_enter();
      return ev;
   endfunction

   function automatic void burst_step(output logic dcl, output logic fsc);
      burst_level = ~burst_level;
      dcl = burst_level;
      fsc = (burst_count == '0);
      burst_count = burst_count + 1'b1;
      if (burst_count >= pcm_pkg::BURST_HALF_CYCLES) begin
         mon_state   = pcm_pkg::ST_LOST;
         burst_count = '0;
         burst_level = 1'b0;
         if (saved_ext) ext_logical = 1'b1;
         gap_enter();
      end
   endfunction

   function automatic pcm_pkg::pcm_rsp_type predict_status(input logic level,
                                                           input logic start);
      pcm_pkg::pcm_rsp_type        r;
      logic                        dcl;
      logic                        fsc;
      logic [pcm_pkg::EVENT_W-1:0] ev;
      dcl = 1'b0;
      fsc = 1'b0;
      ev  = pcm_pkg::EV_NONE;
      if (!cfg_enable) begin
         mon_state   = pcm_pkg::ST_DISABLED;
         ext_logical = 1'b0;
         burst_count = '0;
         burst_level = 1'b0;
         window_restart();
      end else if (mon_state == pcm_pkg::ST_DISABLED) begin
         // this tick's sample is the reference of the first window
         mon_state   = pcm_pkg::ST_ENABLED;
         ext_logical = 1'b1;
         window_restart();
         ev = detect_tick(level);
      end else if (mon_state == pcm_pkg::ST_GENERATING) begin
         burst_step(dcl, fsc);
      end else if (start && (mon_state == pcm_pkg::ST_ENABLED ||
                             mon_state == pcm_pkg::ST_LOST)) begin
         mon_state   = pcm_pkg::ST_GENERATING;
         saved_ext   = ext_logical;
         ext_logical = 1'b0;
         burst_count = '0;
         burst_level = 1'b0;
         burst_step(dcl, fsc);
      end else begin
         ev = detect_tick(level);
      end
      r.clock_state = mon_state;
      if (mon_state == pcm_pkg::ST_DISABLED) r.interface_mode = pcm_pkg::MODE_DISABLED;
      else if (mon_state == pcm_pkg::ST_GENERATING) r.interface_mode = pcm_pkg::MODE_MASTER;
      else r.interface_mode = pcm_pkg::MODE_SLAVE;
      if (r.interface_mode != pcm_pkg::MODE_MASTER) begin
         dcl = 1'b0;
         fsc = 1'b0;
      end
      r.dcl_drive     = dcl;
      r.fsc_drive     = fsc;
      r.ext_pin_level = ext_logical ^ cfg_active_low;
      r.event_code    = ev;
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_status(input pcm_pkg::pcm_rsp_type got,
                                        input pcm_pkg::pcm_rsp_type want);
      check_field("clock_state", want.clock_state, got.clock_state);
      check_field("interface_mode", want.interface_mode, got.interface_mode);
      check_field("dcl_drive", want.dcl_drive, got.dcl_drive);
      check_field("fsc_drive", want.fsc_drive, got.fsc_drive);
      check_field("ext_pin_level", want.ext_pin_level, got.ext_pin_level);
      check_field("event_code", want.event_code, got.event_code);
   endfunction

   function automatic pcm_pkg::pcm_rsp_type status_of(
         input logic [pcm_pkg::STATE_W-1:0] st, input logic [pcm_pkg::MODE_W-1:0] mode,
         input logic dcl, input logic fsc, input logic ext,
         input logic [pcm_pkg::EVENT_W-1:0] ev);
      pcm_pkg::pcm_rsp_type r;
      r.clock_state    = st;
      r.interface_mode = mode;
      r.dcl_drive      = dcl;
      r.fsc_drive      = fsc;
      r.ext_pin_level  = ext;
      r.event_code     = ev;
      return r;
   endfunction

   function automatic dir_row_type tick_row(input logic level, input logic start);
      dir_row_type r;
      r.kind  = ROW_TICK;
      r.index = '0;
      r.data  = '0;
      r.level = level;
      r.start = start;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic dir_row_type checked_row(input logic level, input logic start,
                                               input pcm_pkg::pcm_rsp_type want);
      dir_row_type r;
      r = tick_row(level, start);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic dir_row_type write_row(input logic [pcm_pkg::CSR_IDX_W-1:0] idx,
                                             input logic [pcm_pkg::CSR_DATA_W-1:0] data);
      dir_row_type r;
      r = tick_row(1'b0, 1'b0);
      r.kind  = ROW_WRITE;
      r.index = idx;
      r.data  = data;
      return r;
   endfunction

   // the caller lowers csr_we once the last write of a group is done
   task automatic write_reg(input logic [pcm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pcm_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         pcm_pkg::CSR_ENABLE:         cfg_enable     = data[0];
         pcm_pkg::CSR_EDGE_THRESHOLD: cfg_threshold  = data[pcm_pkg::THR_W-1:0];
         pcm_pkg::CSR_POLL_GAP:       cfg_gap        = data[pcm_pkg::GAP_W-1:0];
         pcm_pkg::CSR_EXT_ACTIVE_LOW: cfg_active_low = data[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic send_tick(input logic level, input logic start, input int idle_pct,
                            input bit use_want, input pcm_pkg::pcm_rsp_type want);
      pcm_pkg::pcm_rsp_type status;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.dcl_level     <= level;
      req_bus.start_request <= start;
      do @(posedge clock); while (!req_bus.ready);
      status = predict_status(level, start);
      pending_status.push_back(use_want ? want : status);
      ticks_sent++;
   endtask

   // bit clock source: runs of steady toggling, stuck levels and noise
   task automatic run_phase(input int n_ticks, input logic en, input int thr, input int gap,
                            input logic act_low, input int idle_pct, input int stall,
                            input int start_rate, input bit squeeze);
      int   seg_left;
      int   half_per;
      int   hold_cnt;
      int   pattern;
      logic level;
      logic start;
      wait_drained();
      write_reg(pcm_pkg::CSR_ENABLE, pcm_pkg::CSR_DATA_W'(en));
      write_reg(pcm_pkg::CSR_EDGE_THRESHOLD, pcm_pkg::CSR_DATA_W'(thr));
      write_reg(pcm_pkg::CSR_POLL_GAP, pcm_pkg::CSR_DATA_W'(gap));
      write_reg(pcm_pkg::CSR_EXT_ACTIVE_LOW, pcm_pkg::CSR_DATA_W'(act_low));
      csr_we    <= 1'b0;
      stall_pct <= stall;
      seg_left = 0;
      half_per = 1;
      hold_cnt = 0;
      pattern  = 0;
      level    = 1'b0;
      for (int k = 0; k < n_ticks; k++) begin
         if (seg_left == 0) begin
            pattern  = $urandom_range(0, 9);
            half_per = $urandom_range(1, 8);
            seg_left = $urandom_range(150, 700);
            level    = 1'($urandom_range(0, 1));
            hold_cnt = 0;
         end
         seg_left--;
         if (pattern < 6) begin
            hold_cnt++;
            if (hold_cnt >= half_per) begin
               level    = ~level;
               hold_cnt = 0;
            end
         end else if (pattern >= 8) begin
            level = 1'($urandom_range(0, 1));
         end
         start = ($urandom_range(999) < start_rate);
         if (squeeze && k == n_ticks / 2) hold_req <= 1'b1;
         send_tick(level, start, idle_pct, 1'b0, '0);
      end
   endtask

   // result side: random stalls, one long hold-off, compare against the predicted queue
   always @(posedge clock) begin : rsp_side
      pcm_pkg::pcm_rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.clock_state    = rsp_bus.clock_state;
         got.interface_mode = rsp_bus.interface_mode;
         got.dcl_drive      = rsp_bus.dcl_drive;
         got.fsc_drive      = rsp_bus.fsc_drive;
         got.ext_pin_level  = rsp_bus.ext_pin_level;
         got.event_code     = rsp_bus.event_code;
         if (pending_status.size() == 0) begin
            $error("result transfer with no status expected");
            error_count++;
         end else begin
            check_status(got, pending_status.pop_front());
         end
         results_seen++;
         if (got.event_code == pcm_pkg::EV_SYNC) sync_events++;
         if (got.event_code == pcm_pkg::EV_LOST) lost_events++;
         if (got.fsc_drive) bursts_seen++;
      end
      if (hold_req && !hold_done) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles++;
         if (hold_cycles >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("pcm_clock_presence_monitor test failed");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid         <= 1'b0;
      req_bus.dcl_level     <= 1'b0;
      req_bus.start_request <= 1'b0;
      csr_we                <= 1'b0;
      csr_index             <= '0;
      csr_wdata             <= '0;
      model_reset();

      // disabled ticks, then enable with a zero gap and run bursts
      dir_rows.push_back(checked_row(1'b1, 1'b1,
         status_of(pcm_pkg::ST_DISABLED, pcm_pkg::MODE_DISABLED, 1'b0, 1'b0, 1'b0,
                   pcm_pkg::EV_NONE)));
      dir_rows.push_back(write_row(pcm_pkg::CSR_EXT_ACTIVE_LOW, 16'd1));
      dir_rows.push_back(checked_row(1'b0, 1'b0,
         status_of(pcm_pkg::ST_DISABLED, pcm_pkg::MODE_DISABLED, 1'b0, 1'b0, 1'b1,
                   pcm_pkg::EV_NONE)));
      dir_rows.push_back(write_row(pcm_pkg::CSR_POLL_GAP, 16'd0));
      dir_rows.push_back(write_row(pcm_pkg::CSR_ENABLE, 16'd1));
      // start on the enabling tick is ignored
      dir_rows.push_back(checked_row(1'b1, 1'b1,
         status_of(pcm_pkg::ST_ENABLED, pcm_pkg::MODE_SLAVE, 1'b0, 1'b0, 1'b0,
                   pcm_pkg::EV_NONE)));
      dir_rows.push_back(checked_row(1'b0, 1'b1,
         status_of(pcm_pkg::ST_GENERATING, pcm_pkg::MODE_MASTER, 1'b1, 1'b1, 1'b1,
                   pcm_pkg::EV_NONE)));
      // rest of the burst, with starts that must be ignored
      for (int k = 0; k < pcm_pkg::BURST_HALF_CYCLES - 1; k++)
         dir_rows.push_back(tick_row(1'($urandom_range(0, 1)), k == 5 || k == 11));
      // start from the lost state abandons the window
      dir_rows.push_back(tick_row(1'b0, 1'b1));
      dir_rows.push_back(tick_row(1'b1, 1'b0));
      // disabling in the middle of a burst
      dir_rows.push_back(write_row(pcm_pkg::CSR_ENABLE, 16'd0));
      dir_rows.push_back(checked_row(1'b1, 1'b1,
         status_of(pcm_pkg::ST_DISABLED, pcm_pkg::MODE_DISABLED, 1'b0, 1'b0, 1'b1,
                   pcm_pkg::EV_NONE)));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_WRITE) begin
            wait_drained();
            write_reg(dir_rows[i].index, dir_rows[i].data);
            if (i + 1 == dir_rows.size() || dir_rows[i + 1].kind != ROW_WRITE)
               csr_we <= 1'b0;
         end else begin
            send_tick(dir_rows[i].level, dir_rows[i].start, 0, dir_rows[i].typed,
                      dir_rows[i].want);
         end
      end

      run_phase(420, 1'b1, 10, 0, 1'b0, 0, 0, 7, 1'b0);
      run_phase(300, 1'b1, 400, 1, 1'b1, 79, 0, 7, 1'b0);
      run_phase(300, 1'b1, 0, 2, 1'b0, 0, 79, 7, 1'b0);
      // long gap after each burst, so starts keep landing in the lost state
      run_phase(120, 1'b1, $urandom_range(0, 400), 65535, 1'b1, 24, 24, 100, 1'b0);
      // gap lowered while one is running, and the long receiver hold-off
      run_phase(320, 1'b1, 200, 5, 1'b1, 0, 0, 7, 1'b1);
      run_phase(60, 1'b0, $urandom_range(0, 400), $urandom_range(0, 65535), 1'b0, 24, 24,
                50, 1'b0);
      run_phase(200, 1'b1, $urandom_range(0, 60), $urandom_range(0, 3),
                1'($urandom_range(0, 1)), 0, 0, 7, 1'b0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d ticks over seven register settings, %0d results checked",
               ticks_sent, results_seen);
      $display("saw %0d clock-present and %0d clock-lost events, %0d bursts",
               sync_events, lost_events, bursts_seen);
      if (error_count == 0)
         $display("pcm_clock_presence_monitor test passed");
      else
         $display("pcm_clock_presence_monitor test failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/pcm_pkg.sv
sv/pcm_if.sv
sv/pcm_req_fifo.sv
sv/pcm_mon_core.sv
sv/pcm_clock_presence_monitor.sv
tb/tb_pcm_clock_presence_monitor.sv
